// ===== rtl/led_strip_spi_frame_encoder_defines.svh =====
// assertion macros for the led strip spi frame encoder
`ifndef LED_STRIP_SPI_FRAME_ENCODER_DEFINES_SVH
`define LED_STRIP_SPI_FRAME_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LSFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lsfe check failed");

// next-cycle implication, disabled while reset is asserted
`define LSFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lsfe check failed");

`endif

// ===== rtl/lsfe_pkg.sv =====
// shared types, constants and helper functions of the led strip spi frame encoder
`default_nettype none

package lsfe_pkg;

	localparam int LED_COUNT_DEF = 16;

	localparam logic [7:0] CODE_ONE  = 8'hF0;
	localparam logic [7:0] CODE_ZERO = 8'hC0;

	localparam logic [6:0] PERCENT_FULL = 7'd100;

	// floor(p / 100) == (p * 5243) >> 19 for every p below 2**15
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam int         ADDR_W          = 2;
	localparam logic [1:0] ADDR_BRIGHTNESS = 2'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SHOW
	} state_t;

	typedef enum logic [1:0] {
		CH_GREEN,
		CH_RED,
		CH_BLUE
	} ch_t;

	typedef enum logic {
		REQ_SET  = 1'b0,
		REQ_SHOW = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] led_index;
		logic [7:0] red_value;
		logic [7:0] green_value;
		logic [7:0] blue_value;
	} req_t;

	typedef struct packed {
		logic [63:0] spi_word;
		logic        frame_last;
	} res_t;

	typedef struct packed {
		logic capture;
		logic commit;
		logic walk_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
	} status_t;

	function automatic logic [7:0] div100(input logic [14:0] p);
		logic [27:0] m;
		m = 28'(p) * 28'(RECIP_100);
		return m[RECIP_SHIFT +: 8];
	endfunction

	function automatic logic [63:0] encode_byte(input logic [7:0] b);
		logic [63:0] w;
		for (int i = 0; i < 8; i++) begin
			w[8*i +: 8] = b[i] ? CODE_ONE : CODE_ZERO;
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lsfe_regs.sv =====
// apb register file holding the brightness setting
`default_nettype none

module lsfe_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [lsfe_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output logic      [6:0]                brightness
);
	import lsfe_pkg::*;

	logic [6:0] bright_q;
	logic       wr_en;
	logic [6:0] wr_val;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_BRIGHTNESS);
	// clamp writes above full scale
	assign wr_val = (pwdata[6:0] > PERCENT_FULL) ? PERCENT_FULL : pwdata[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= PERCENT_FULL;
		end else if (wr_en) begin
			bright_q <= wr_val;
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == ADDR_BRIGHTNESS) begin
			prdata = {25'd0, bright_q};
		end
	end

	assign brightness = bright_q;

endmodule

`default_nettype wire

// ===== rtl/lsfe_ctrl.sv =====
// controller state machine sequencing set and show requests
`default_nettype none

module lsfe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              req_type,
	input  wire lsfe_pkg::status_t status,
	output lsfe_pkg::cmd_t         cmd,
	output logic                   busy
);
	import lsfe_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (req_type == REQ_SHOW) ? ST_SHOW : ST_SCALE;
				end
			end
			ST_SCALE: begin
				state_d = ST_IDLE;
			end
			ST_SHOW: begin
				if (status.walk_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy           = 1'b0;
				cmd.capture    = accept;
				cmd.walk_start = accept && (req_type == REQ_SHOW);
			end
			ST_SCALE: begin
				cmd.commit = 1'b1;
			end
			ST_SHOW: begin
				cmd.emit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/lsfe_datapath.sv =====
// colour store, brightness scaling and spi bit encoding
`default_nettype none

module lsfe_datapath #(
	parameter int LED_COUNT = lsfe_pkg::LED_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lsfe_pkg::cmd_t    cmd,
	input  wire lsfe_pkg::req_t    req,
	input  wire logic [6:0]        brightness,
	output lsfe_pkg::status_t      status,
	output lsfe_pkg::res_t         result,
	output logic                   result_valid
);
	import lsfe_pkg::*;

	localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	logic [23:0]      store_q [LED_COUNT];
	logic [7:0]       idx_s1;
	logic [14:0]      g_prod_s1;
	logic [14:0]      r_prod_s1;
	logic [14:0]      b_prod_s1;
	logic [LED_W-1:0] led_q;
	ch_t              ch_q;
	logic [23:0]      entry;
	logic [7:0]       chan_byte;
	logic             idx_ok;
	res_t             res_q;
	logic             valid_q;

	// first stage: raw products; the user must keep brightness stable while busy, the block does not enforce it
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_s1    <= req.led_index;
			g_prod_s1 <= 15'(req.green_value) * 15'(brightness);
			r_prod_s1 <= 15'(req.red_value) * 15'(brightness);
			b_prod_s1 <= 15'(req.blue_value) * 15'(brightness);
		end
	end

	assign idx_ok = (idx_s1 < 8'(LED_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				store_q[i] <= '0;
			end
		end else if (cmd.commit && idx_ok) begin
			store_q[idx_s1[LED_W-1:0]] <= {div100(g_prod_s1), div100(r_prod_s1),
				div100(b_prod_s1)};
		end
	end

	// walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q <= '0;
			ch_q  <= CH_GREEN;
		end else if (cmd.walk_start) begin
			led_q <= '0;
			ch_q  <= CH_GREEN;
		end else if (cmd.emit) begin
			if (ch_q == CH_BLUE) begin
				ch_q  <= CH_GREEN;
				led_q <= led_q + 1'b1;
			end else begin
				ch_q <= ch_t'(ch_q + 2'd1);
			end
		end
	end

	assign entry = store_q[led_q];

	always_comb begin
		case (ch_q)
			CH_GREEN: chan_byte = entry[23:16];
			CH_RED:   chan_byte = entry[15:8];
			CH_BLUE:  chan_byte = entry[7:0];
			default:  chan_byte = entry[7:0];
		endcase
	end

	assign status.walk_last = (led_q == LED_W'(LED_COUNT - 1)) && (ch_q == CH_BLUE);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.spi_word   <= encode_byte(chan_byte);
			res_q.frame_last <= status.walk_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	assign result       = res_q;
	assign result_valid = valid_q;

endmodule

`default_nettype wire

// ===== rtl/led_strip_spi_frame_encoder.sv =====
// top level of the led strip spi frame encoder
`default_nettype none
`include "led_strip_spi_frame_encoder_defines.svh"

// A request transfer is taken at a rising edge with start high and busy low.
// A set request scales red, green and blue by the brightness register as
// floor(value*brightness/100) and writes them, in green, red, blue order, to
// the entry at led_index; an index of LED_COUNT or more changes nothing. A
// set keeps busy high in the cycle after the transfer, so a new request waits
// until the set is written: the product is registered and then divided by a
// constant reciprocal on the way into the store. A show keeps busy high while
// the single store read walks LED by LED and colour by colour. Each colour
// byte becomes one 64-bit word of spi bytes, 0xF0 for a one bit and 0xC0 for
// a zero bit, most significant bit first in the top byte. Words appear one
// per cycle after the state register enters the show state and the result
// register loads, each on the result ports for exactly one cycle with
// result_valid high; the receiver cannot stall them, so it must take every
// strobe. The last word of a frame has frame_last set. The store is cleared
// to black by reset at once. Write the brightness register over apb at
// address 0 only while the block is idle; values above 100 are stored as 100.
module led_strip_spi_frame_encoder #(
	parameter int LED_COUNT = lsfe_pkg::LED_COUNT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request channel
	input  wire logic                        start,
	output logic                             busy,
	input  wire lsfe_pkg::req_t              req,
	// result channel
	output lsfe_pkg::res_t                   result,
	output logic                             result_valid,
	// configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lsfe_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import lsfe_pkg::*;

	cmd_t       cmd;
	status_t    status;
	logic [6:0] brightness;

	// brightness register
	lsfe_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.brightness (brightness)
	);

	// sequencing of set and show
	lsfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	// store, scaling and encoding
	lsfe_datapath #(
		.LED_COUNT (LED_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req          (req),
		.brightness   (brightness),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

	// any accepted request holds the block busy in the following cycle
	`LSFE_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// a word seen while idle can only be the closing word of a frame
	`LSFE_ASSERT_IMP(a_idle_word_last, clk, arst_n, result_valid && !busy, result.frame_last)
	// the closing word is followed by a gap before any new frame
	`LSFE_ASSERT_NXT(a_last_gap, clk, arst_n, result_valid && result.frame_last, !result_valid)

endmodule

`default_nettype wire
